### src/vac_pkg.sv
package vac_pkg;

    localparam int ACC_W      = 16;
    localparam int DIFF_W     = ACC_W + 1;
    localparam int SQ_W       = 2 * DIFF_W - 2;
    localparam int RAD_W      = SQ_W + 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int MAG_W      = 17;
    localparam int SCORE_W    = 7;
    localparam int LEVEL_W    = 2;
    localparam int SUM_W      = 24;
    localparam int CAL_CNT_W  = 7;

    localparam int CAL_SAMPLES = 100;
    localparam int ROOT_CNT_W  = $clog2(ROOT_W);

    // |sum| of a full run stays below 2**22; the shift keeps the reciprocal exact there
    localparam int DIV_ABS_W   = SUM_W - 2;
    localparam int DIV_SHIFT   = 29;
    localparam int DIV_RECIP_W = DIV_SHIFT + 1;
    localparam int DIV_PROD_W  = DIV_ABS_W + DIV_RECIP_W;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
        DIV_RECIP_W'((2**DIV_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

    localparam logic [MAG_W-1:0] CAUTION_RESET = MAG_W'(1044);
    localparam logic [MAG_W-1:0] DANGER_RESET  = MAG_W'(2505);
    localparam logic [MAG_W-1:0] MAG_MAX       = {MAG_W{1'b1}};

    localparam logic [MAG_W-1:0]   SCORE_FLOOR = MAG_W'(41);
    localparam logic [SCORE_W-1:0] SCORE_BASE  = SCORE_W'(10);
    localparam logic [SCORE_W-1:0] SCORE_MAX   = SCORE_W'(90);
    localparam int NUM_STEPS = 53;
    localparam int IDX_W     = 6;

    localparam logic [MAG_W-1:0] SCORE_STEP [NUM_STEPS] = '{
        17'd137,    17'd425,    17'd733,    17'd1061,   17'd1412,
        17'd1786,   17'd2186,   17'd2613,   17'd3070,   17'd3557,
        17'd4077,   17'd4633,   17'd5226,   17'd5860,   17'd6537,
        17'd7260,   17'd8032,   17'd8857,   17'd9738,   17'd10679,
        17'd11683,  17'd12756,  17'd13902,  17'd15126,  17'd16433,
        17'd17829,  17'd19320,  17'd20912,  17'd22613,  17'd24429,
        17'd26369,  17'd28440,  17'd30653,  17'd33016,  17'd35539,
        17'd38234,  17'd41113,  17'd44187,  17'd47470,  17'd50977,
        17'd54721,  17'd58721,  17'd62993,  17'd67555,  17'd72427,
        17'd77630,  17'd83188,  17'd89123,  17'd95462,  17'd102232,
        17'd109462, 17'd117184, 17'd125431
    };

    typedef enum logic [LEVEL_W-1:0] {
        LVL_SAFE    = 2'd0,
        LVL_CAUTION = 2'd1,
        LVL_DANGER  = 2'd2
    } t_level;

    typedef enum logic {
        OP_CAL  = 1'b0,
        OP_MEAS = 1'b1
    } t_op;

    typedef enum logic {
        CFG_CAUTION = 1'b0,
        CFG_DANGER  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_BASE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_SCORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cal_add;
        logic div_init;
        logic div_step;
        logic base_load;
        logic diff_load;
        logic sq_load;
    } t_lane_ctl;

    function automatic logic [MAG_W-1:0] score_step(input logic [IDX_W-1:0] idx);
        logic [MAG_W-1:0] v;
        v = MAG_MAX;
        if (idx < IDX_W'(NUM_STEPS)) begin
            v = SCORE_STEP[idx];
        end
        return v;
    endfunction

endpackage

### src/vac_in_if.sv
interface vac_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [vac_pkg::ACC_W-1:0]  acc_x;
    logic signed [vac_pkg::ACC_W-1:0]  acc_y;
    logic signed [vac_pkg::ACC_W-1:0]  acc_z;

    modport source (output valid, output op, output acc_x, output acc_y, output acc_z,
                    input ready);
    modport sink   (input valid, input op, input acc_x, input acc_y, input acc_z,
                    output ready);
endinterface

### src/vac_out_if.sv
interface vac_out_if;
    logic                          valid;
    logic                          ready;
    logic [vac_pkg::LEVEL_W-1:0]   level;
    logic [vac_pkg::MAG_W-1:0]     magnitude;
    logic [vac_pkg::SCORE_W-1:0]   score_tenths;
    logic                          alert;
    logic                          baseline_ready;

    modport source (output valid, output level, output magnitude, output score_tenths,
                    output alert, output baseline_ready, input ready);
    modport sink   (input valid, input level, input magnitude, input score_tenths,
                    input alert, input baseline_ready, output ready);
endinterface

### src/vibration_alarm_classifier_unit.sv
// Measurement transaction: square, sum, 17-step square root and 6-step score search, then
// the result is registered; a calibration transaction adds to the sums, and one that ends
// a run also runs the baseline division. A new transaction is accepted only after the last
// result is registered, and that waits while the output register is still full.
// Reset (synchronous, active low) clears sums, baselines, level history and restores
// thresholds to 1044 and 2505.
module vibration_alarm_classifier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vac_in_if.sink                         i_in,
    vac_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [vac_pkg::MAG_W-1:0]      i_cfg_data
);

    vac_pkg::t_state                  r_state, n_state;
    logic                             r_op, n_op;
    logic [vac_pkg::CAL_CNT_W-1:0]    r_cal_cnt, n_cal_cnt;
    logic                             r_ready_flag, n_ready_flag;
    vac_pkg::t_level                  r_last_level, n_last_level;
    logic [vac_pkg::MAG_W-1:0]        r_mag, n_mag;
    logic [vac_pkg::IDX_W-1:0]        r_cnt, n_cnt;
    logic [vac_pkg::IDX_W-1:0]        r_bit, n_bit;
    logic [vac_pkg::MAG_W-1:0]        r_caution;
    logic [vac_pkg::MAG_W-1:0]        r_danger;

    logic                             r_out_valid, n_out_valid;
    vac_pkg::t_level                  r_o_level, n_o_level;
    logic [vac_pkg::MAG_W-1:0]        r_o_mag, n_o_mag;
    logic [vac_pkg::SCORE_W-1:0]      r_o_score, n_o_score;
    logic                             r_o_alert, n_o_alert;
    logic                             r_o_bready, n_o_bready;

    vac_pkg::t_lane_ctl               w_ctl;
    logic [vac_pkg::SQ_W-1:0]         w_sq_x, w_sq_y, w_sq_z;
    logic                             w_root_start;
    logic [vac_pkg::RAD_W-1:0]        w_rad;
    logic [vac_pkg::ROOT_W-1:0]       w_root;
    logic                             w_root_done;
    logic                             w_accept;
    logic [vac_pkg::CAL_CNT_W:0]      w_cal_next;
    logic [vac_pkg::IDX_W-1:0]        w_cand;
    logic                             w_take;
    vac_pkg::t_level                  w_level;
    logic                             w_alert;
    logic [vac_pkg::SCORE_W-1:0]      w_score_raw;
    logic [vac_pkg::SCORE_W-1:0]      w_score;

    vac_lane u_lane_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
                       .i_acc(i_in.acc_x), .o_sq(w_sq_x));
    vac_lane u_lane_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
                       .i_acc(i_in.acc_y), .o_sq(w_sq_y));
    vac_lane u_lane_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
                       .i_acc(i_in.acc_z), .o_sq(w_sq_z));

    assign w_rad = vac_pkg::RAD_W'(w_sq_x) + vac_pkg::RAD_W'(w_sq_y)
                 + vac_pkg::RAD_W'(w_sq_z);

    vac_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_rad   (w_rad),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    assign i_in.ready           = (r_state == vac_pkg::S_IDLE);
    assign w_accept             = i_in.valid && (r_state == vac_pkg::S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.level          = r_o_level;
    assign o_out.magnitude      = r_o_mag;
    assign o_out.score_tenths   = r_o_score;
    assign o_out.alert          = r_o_alert;
    assign o_out.baseline_ready = r_o_bready;

    assign w_cal_next = {1'b0, r_cal_cnt} + 1'b1;

    // binary search for the number of score steps at or below the magnitude
    assign w_cand = r_cnt | r_bit;
    assign w_take = (w_cand <= vac_pkg::IDX_W'(vac_pkg::NUM_STEPS))
                 && (r_mag >= vac_pkg::score_step(w_cand - 1'b1));

    always_comb begin
        if (r_mag < r_caution) begin
            w_level = vac_pkg::LVL_SAFE;
        end else if (r_mag < r_danger) begin
            w_level = vac_pkg::LVL_CAUTION;
        end else begin
            w_level = vac_pkg::LVL_DANGER;
        end
    end

    assign w_alert = ((w_level == vac_pkg::LVL_CAUTION) && (r_last_level == vac_pkg::LVL_SAFE))
                  || ((w_level == vac_pkg::LVL_DANGER) && (r_last_level != vac_pkg::LVL_DANGER));
    assign w_score_raw = vac_pkg::SCORE_BASE + vac_pkg::SCORE_W'(r_cnt);
    assign w_score = (r_mag < vac_pkg::SCORE_FLOOR) ? '0
                   : (w_score_raw > vac_pkg::SCORE_MAX) ? vac_pkg::SCORE_MAX : w_score_raw;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_cal_cnt    = r_cal_cnt;
        n_ready_flag = r_ready_flag;
        n_last_level = r_last_level;
        n_mag        = r_mag;
        n_cnt        = r_cnt;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_o_level    = r_o_level;
        n_o_mag      = r_o_mag;
        n_o_score    = r_o_score;
        n_o_alert    = r_o_alert;
        n_o_bready   = r_o_bready;
        w_ctl        = '0;
        w_root_start = 1'b0;

        case (r_state)
            vac_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op = i_in.op;
                    if (i_in.op == vac_pkg::OP_CAL) begin
                        w_ctl.cal_add = 1'b1;
                        if (w_cal_next >= (vac_pkg::CAL_CNT_W+1)'(vac_pkg::CAL_SAMPLES)) begin
                            n_cal_cnt = '0;
                            n_state   = vac_pkg::S_DIV_INIT;
                        end else begin
                            n_cal_cnt = w_cal_next[vac_pkg::CAL_CNT_W-1:0];
                            n_state   = vac_pkg::S_DONE;
                        end
                    end else begin
                        w_ctl.diff_load = 1'b1;
                        n_state         = vac_pkg::S_SQUARE;
                    end
                end
            end
            vac_pkg::S_DIV_INIT: begin
                w_ctl.div_init = 1'b1;
                n_state        = vac_pkg::S_DIV;
            end
            vac_pkg::S_DIV: begin
                w_ctl.div_step = 1'b1;
                n_state        = vac_pkg::S_BASE;
            end
            vac_pkg::S_BASE: begin
                w_ctl.base_load = 1'b1;
                n_ready_flag    = 1'b1;
                n_state         = vac_pkg::S_DONE;
            end
            vac_pkg::S_SQUARE: begin
                w_ctl.sq_load = 1'b1;
                n_state       = vac_pkg::S_SUM;
            end
            vac_pkg::S_SUM: begin
                w_root_start = 1'b1;
                n_state      = vac_pkg::S_ROOT;
            end
            vac_pkg::S_ROOT: begin
                if (w_root_done) begin
                    n_mag   = vac_pkg::MAG_W'(w_root);
                    n_cnt   = '0;
                    n_bit   = {1'b1, {(vac_pkg::IDX_W-1){1'b0}}};
                    n_state = vac_pkg::S_SCORE;
                end
            end
            vac_pkg::S_SCORE: begin
                if (w_take) begin
                    n_cnt = w_cand;
                end
                n_bit = r_bit >> 1;
                if (r_bit[0]) begin
                    n_state = vac_pkg::S_DONE;
                end
            end
            vac_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_bready  = r_ready_flag;
                    if (r_op == vac_pkg::OP_MEAS) begin
                        n_o_level    = w_level;
                        n_o_mag      = r_mag;
                        n_o_score    = w_score;
                        n_o_alert    = w_alert;
                        n_last_level = w_level;
                    end else begin
                        n_o_level = vac_pkg::LVL_SAFE;
                        n_o_mag   = '0;
                        n_o_score = '0;
                        n_o_alert = 1'b0;
                    end
                    n_state = vac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vac_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vac_pkg::S_IDLE;
            r_cal_cnt    <= '0;
            r_ready_flag <= 1'b0;
            r_last_level <= vac_pkg::LVL_SAFE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cal_cnt    <= n_cal_cnt;
            r_ready_flag <= n_ready_flag;
            r_last_level <= n_last_level;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_mag      <= n_mag;
        r_cnt      <= n_cnt;
        r_bit      <= n_bit;
        r_o_level  <= n_o_level;
        r_o_mag    <= n_o_mag;
        r_o_score  <= n_o_score;
        r_o_alert  <= n_o_alert;
        r_o_bready <= n_o_bready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caution <= vac_pkg::CAUTION_RESET;
            r_danger  <= vac_pkg::DANGER_RESET;
        end else if (i_cfg_we) begin
            case (vac_pkg::t_cfg_idx'(i_cfg_idx))
                vac_pkg::CFG_CAUTION: r_caution <= i_cfg_data;
                vac_pkg::CFG_DANGER:  r_danger  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### src/vac_lane.sv
module vac_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vac_pkg::t_lane_ctl                i_ctl,
    input  logic signed [vac_pkg::ACC_W-1:0]  i_acc,
    output logic [vac_pkg::SQ_W-1:0]          o_sq
);

    logic signed [vac_pkg::SUM_W-1:0]      r_sum;
    logic signed [vac_pkg::ACC_W-1:0]      r_base;
    logic signed [vac_pkg::DIFF_W-1:0]     r_diff;
    logic [vac_pkg::SQ_W-1:0]              r_sq;
    logic [vac_pkg::DIV_ABS_W-1:0]         r_dabs;
    logic [vac_pkg::ACC_W-1:0]             r_dq;
    logic                                  r_dneg;

    logic signed [2*vac_pkg::DIFF_W-1:0]   w_prod;
    logic [vac_pkg::SUM_W-1:0]             w_abs;
    logic [vac_pkg::DIV_PROD_W-1:0]        w_quot;
    logic signed [vac_pkg::ACC_W-1:0]      w_qlo;
    logic signed [vac_pkg::ACC_W-1:0]      n_base;

    assign w_prod = r_diff * r_diff;
    assign w_abs  = r_sum[vac_pkg::SUM_W-1] ? vac_pkg::SUM_W'(-r_sum)
                                            : vac_pkg::SUM_W'(r_sum);
    assign w_quot = vac_pkg::DIV_PROD_W'(r_dabs) * vac_pkg::DIV_PROD_W'(vac_pkg::DIV_RECIP);
    assign w_qlo  = r_dq;
    assign n_base = r_dneg ? -w_qlo : w_qlo;
    assign o_sq   = r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_base <= '0;
        end else begin
            if (i_ctl.cal_add) begin
                r_sum <= r_sum + vac_pkg::SUM_W'(i_acc);
            end
            if (i_ctl.base_load) begin
                r_sum  <= '0;
                r_base <= n_base;
            end
        end
    end

    // divide |sum| by the sample count with a scaled reciprocal, then restore the sign
    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_load) begin
            r_diff <= vac_pkg::DIFF_W'(i_acc) - vac_pkg::DIFF_W'(r_base);
        end
        if (i_ctl.sq_load) begin
            r_sq <= w_prod[vac_pkg::SQ_W-1:0];
        end
        if (i_ctl.div_init) begin
            r_dneg <= r_sum[vac_pkg::SUM_W-1];
            r_dabs <= w_abs[vac_pkg::DIV_ABS_W-1:0];
        end
        if (i_ctl.div_step) begin
            r_dq <= w_quot[vac_pkg::DIV_SHIFT +: vac_pkg::ACC_W];
        end
    end

endmodule

### src/vac_isqrt.sv
module vac_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vac_pkg::RAD_W-1:0]     i_rad,
    output logic [vac_pkg::ROOT_W-1:0]    o_root,
    output logic                          o_done
);

    localparam int REM_W = vac_pkg::ROOT_W + 2;

    logic                              r_busy;
    logic                              r_done;
    logic [vac_pkg::ROOT_CNT_W-1:0]    r_cnt;
    logic [vac_pkg::RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]                  r_rem;
    logic [vac_pkg::ROOT_W-1:0]        r_root;

    logic [REM_W+1:0]                  w_rsh;
    logic [REM_W+1:0]                  w_trial;
    logic                              w_ge;

    assign w_rsh   = {r_rem, r_rad[vac_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rsh >= w_trial);
    assign o_root  = r_root;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == vac_pkg::ROOT_CNT_W'(vac_pkg::ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one root bit per cycle, two radicand bits consumed per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[vac_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? REM_W'(w_rsh - w_trial) : REM_W'(w_rsh);
            r_root <= {r_root[vac_pkg::ROOT_W-2:0], w_ge};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

endmodule

### tb/vac_result_checker.sv
`timescale 1ns / 1ps

module vac_result_checker
    import vac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    vac_in_if                 i_in_mon,
    vac_out_if                i_out_mon,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [MAG_W-1:0]  i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);

    typedef struct packed {
        t_level              level;
        logic [MAG_W-1:0]    magnitude;
        logic [SCORE_W-1:0]  score_tenths;
        logic                alert;
        logic                baseline_ready;
    } t_report;

    t_report           predicted_reports[$];
    int                mismatches;

    logic [MAG_W-1:0]  thr_caution;
    logic [MAG_W-1:0]  thr_danger;
    int                acc_sum_x, acc_sum_y, acc_sum_z;
    int                cal_seen;
    int                base_x, base_y, base_z;
    t_level            prev_level;
    logic              have_baseline;

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int i = 20; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= n) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic logic [SCORE_W-1:0] score_tenths_of(input logic [MAG_W-1:0] mag);
        int n;
        if (mag < SCORE_FLOOR) begin
            return '0;
        end
        n = SCORE_BASE;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (mag >= SCORE_STEP[i]) begin
                n++;
            end
        end
        if (n > SCORE_MAX) begin
            n = SCORE_MAX;
        end
        return SCORE_W'(n);
    endfunction

    // Advance the sample state by one transaction and return the report it produces.
    function automatic t_report classify_sample(input t_op op,
                                                input logic signed [ACC_W-1:0] ax,
                                                input logic signed [ACC_W-1:0] ay,
                                                input logic signed [ACC_W-1:0] az);
        t_report           r;
        longint            dx, dy, dz;
        longint unsigned   energy;
        longint unsigned   root;
        logic [MAG_W-1:0]  mag;
        t_level            lvl;
        r = '0;
        if (op == OP_CAL) begin
            acc_sum_x += ax;
            acc_sum_y += ay;
            acc_sum_z += az;
            cal_seen++;
            if (cal_seen >= CAL_SAMPLES) begin
                // integer divide truncates toward zero, as the baseline must
                base_x = acc_sum_x / CAL_SAMPLES;
                base_y = acc_sum_y / CAL_SAMPLES;
                base_z = acc_sum_z / CAL_SAMPLES;
                acc_sum_x = 0;
                acc_sum_y = 0;
                acc_sum_z = 0;
                cal_seen = 0;
                have_baseline = 1'b1;
            end
            r.baseline_ready = have_baseline;
            return r;
        end
        dx = longint'(ax) - base_x;
        dy = longint'(ay) - base_y;
        dz = longint'(az) - base_z;
        energy = dx * dx + dy * dy + dz * dz;
        root = floor_root(energy);
        mag = (root > MAG_MAX) ? MAG_MAX : MAG_W'(root);
        // caution is tested first, so out-of-order thresholds give safe below caution
        if (mag < thr_caution) begin
            lvl = LVL_SAFE;
        end else if (mag < thr_danger) begin
            lvl = LVL_CAUTION;
        end else begin
            lvl = LVL_DANGER;
        end
        r.level = lvl;
        r.magnitude = mag;
        r.score_tenths = score_tenths_of(mag);
        r.alert = (lvl == LVL_CAUTION && prev_level == LVL_SAFE) ||
                  (lvl == LVL_DANGER && prev_level != LVL_DANGER);
        r.baseline_ready = have_baseline;
        prev_level = lvl;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            predicted_reports.delete();
            mismatches = 0;
            thr_caution = CAUTION_RESET;
            thr_danger = DANGER_RESET;
            acc_sum_x = 0;
            acc_sum_y = 0;
            acc_sum_z = 0;
            cal_seen = 0;
            base_x = 0;
            base_y = 0;
            base_z = 0;
            prev_level = LVL_SAFE;
            have_baseline = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CAUTION: thr_caution = i_cfg_data;
                    CFG_DANGER:  thr_danger = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.level = t_level'(i_out_mon.level);
                got.magnitude = i_out_mon.magnitude;
                got.score_tenths = i_out_mon.score_tenths;
                got.alert = i_out_mon.alert;
                got.baseline_ready = i_out_mon.baseline_ready;
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none actual level %0d mag %0d",
                             $time, got.level, got.magnitude);
                    mismatches++;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("magnitude", want.magnitude, got.magnitude);
                    check_field("score_tenths", want.score_tenths, got.score_tenths);
                    check_field("alert", want.alert, got.alert);
                    check_field("baseline_ready", want.baseline_ready, got.baseline_ready);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predicted_reports.push_back(classify_sample(t_op'(i_in_mon.op),
                    i_in_mon.acc_x, i_in_mon.acc_y, i_in_mon.acc_z));
            end
        end
        o_pending <= predicted_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/vibration_alarm_classifier_unit_test.sv
`timescale 1ns / 1ps

module vibration_alarm_classifier_unit_test;
    import vac_pkg::*;

    localparam int TOTAL_ITEMS = 870;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [MAG_W-1:0]  cfg_data;
    int                pending;
    int                fail_count;

    vac_in_if  in_ch ();
    vac_out_if out_ch ();

    bit                hold_req = 1'b0;
    int                items_sent = 0;
    int                burst_left = 1;
    int                cal_sent = 0;
    int                est_ctr[3] = '{0, 0, 0};
    int                run_ctr[3] = '{0, 0, 0};
    int                cur_caution = CAUTION_RESET;
    int                cur_danger = DANGER_RESET;

    vibration_alarm_classifier_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    vac_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [ACC_W-1:0] clip_axis(input int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[ACC_W-1:0];
    endfunction

    function automatic int rand_axis();
        return $signed(16'($urandom()));
    endfunction

    // Offer one transaction and hold it until accepted; idle between bursts.
    task automatic push(input t_op op, input int x, input int y, input int z);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.acc_x <= clip_axis(x);
        in_ch.acc_y <= clip_axis(y);
        in_ch.acc_z <= clip_axis(z);
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        if (op == OP_CAL) begin
            cal_sent++;
            if (cal_sent == CAL_SAMPLES) begin
                cal_sent = 0;
                est_ctr = run_ctr;
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 35);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = $urandom_range(1, 16);
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_thresholds(input int c, input int d);
        cur_caution = c;
        cur_danger = d;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CAUTION;
        cfg_data <= MAG_W'(c);
        @(posedge clk);
        cfg_idx  <= CFG_DANGER;
        cfg_data <= MAG_W'(d);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic calibrate(input int len);
        int mode;
        int noise;
        int s[3];
        mode = $urandom_range(0, 2);
        noise = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 1) ? 7 : 300);
        for (int a = 0; a < 3; a++) begin
            case (mode)
                0: run_ctr[a] = int'($urandom_range(0, 1200)) - 600;
                1: run_ctr[a] = rand_axis();
                default: run_ctr[a] = $urandom_range(0, 1) ? 32767 : -32768;
            endcase
        end
        repeat (len) begin
            if (items_sent < TOTAL_ITEMS) begin
                for (int a = 0; a < 3; a++) begin
                    s[a] = run_ctr[a] + int'($urandom_range(0, 2 * noise)) - noise;
                end
                push(OP_CAL, s[0], s[1], s[2]);
            end
        end
    endtask

    task automatic random_item();
        int kind;
        int t;
        int axis;
        int v[3];
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            push(OP_CAL, rand_axis(), rand_axis(), rand_axis());
        end else if (kind <= 3) begin
            push(OP_MEAS, rand_axis(), rand_axis(), rand_axis());
        end else begin
            case (kind % 4)
                0: t = cur_caution + int'($urandom_range(0, 40)) - 20;
                1: t = cur_danger + int'($urandom_range(0, 40)) - 20;
                2: t = $urandom_range(0, 150);
                default: t = $urandom_range(0, 9000);
            endcase
            for (int a = 0; a < 3; a++) begin
                v[a] = est_ctr[a] + int'($urandom_range(0, 4)) - 2;
            end
            axis = $urandom_range(0, 2);
            v[axis] += $urandom_range(0, 1) ? t : -t;
            push(OP_MEAS, v[0], v[1], v[2]);
        end
    endtask

    // Receiver: random stall pattern, plus a long hold-off on request.
    initial begin
        int run;
        int duty;
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                run = $urandom_range(1, 40);
                case ($urandom_range(0, 4))
                    0, 1:    duty = 100;
                    2:       duty = 85;
                    3:       duty = 50;
                    default: duty = 15;
                endcase
                repeat (run) begin
                    out_ch.ready <= ($urandom_range(0, 99) < duty);
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        int phase;
        int c;
        int d;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_MEAS;
        in_ch.acc_x <= '0;
        in_ch.acc_y <= '0;
        in_ch.acc_z <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= CFG_CAUTION;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero baseline, reset thresholds: score floor, first step, level edges
        push(OP_MEAS, 0, 0, 0);
        push(OP_MEAS, 40, 0, 0);
        push(OP_MEAS, 0, -41, 0);
        push(OP_MEAS, 0, 0, 137);
        push(OP_MEAS, 1043, 0, 0);
        push(OP_MEAS, 1044, 0, 0);
        push(OP_MEAS, 0, 2000, 0);
        push(OP_MEAS, 0, 0, -2505);
        push(OP_MEAS, 3000, 0, 0);
        push(OP_MEAS, 2000, 0, 0);
        push(OP_MEAS, 2600, 0, 0);
        push(OP_MEAS, 0, 0, 0);
        push(OP_MEAS, 2505, 0, 0);
        push(OP_MEAS, -32768, -32768, -32768);
        push(OP_MEAS, 32767, 32767, 32767);
        push(OP_MEAS, -32768, 32767, 0);
        push(OP_MEAS, 0, 0, 0);
        // a lone calibration transaction must not move the baseline yet
        push(OP_CAL, 1, 2, 3);
        run_ctr = '{0, 0, 0};
        push(OP_MEAS, 1044, 0, 0);

        // thresholds out of order: caution wins below its own level
        drain();
        set_thresholds(3000, 1000);
        push(OP_MEAS, 2000, 0, 0);
        push(OP_MEAS, 3000, 0, 0);
        push(OP_MEAS, 500, 0, 0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            drain();
            case (phase)
                0: begin c = CAUTION_RESET; d = DANGER_RESET; end
                1: begin c = 0; d = 0; end
                2: begin c = MAG_MAX; d = MAG_MAX; end
                3: begin c = $urandom_range(2000, 6000); d = c - int'($urandom_range(1, 1500)); end
                4: begin c = 0; d = MAG_MAX; end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        c = $urandom_range(0, MAG_MAX);
                        d = $urandom_range(0, MAG_MAX);
                    end else begin
                        c = $urandom_range(0, 6000);
                        d = $urandom_range(0, 9000);
                    end
                end
            endcase
            set_thresholds(c, d);
            if (phase == 2 || phase == 7) begin
                hold_req = 1'b1;
            end
            if (phase == 0 || phase == 4 || $urandom_range(0, 2) == 0) begin
                if (phase == 0 || phase == 4 || $urandom_range(0, 1) == 1) begin
                    calibrate(CAL_SAMPLES - cal_sent);
                end else begin
                    calibrate($urandom_range(1, 30));
                end
            end
            repeat ($urandom_range(60, 120)) begin
                if (items_sent < TOTAL_ITEMS) begin
                    random_item();
                end
            end
            phase++;
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
